>>> rtl/histogram_bin_engine_macros.svh
// ---------------------------------------------------------------------------
// histogram_bin_engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_BIN_ENGINE_MACROS_SVH
`define HISTOGRAM_BIN_ENGINE_MACROS_SVH

// same-cycle implication
`define HBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hbe_pkg.sv
// ---------------------------------------------------------------------------
// hbe_pkg
// Types and fixed field widths of the histogram bin engine.
// ---------------------------------------------------------------------------
`default_nettype none

package hbe_pkg;

  localparam int OP_W       = 3;
  localparam int BIN_W      = 8;
  localparam int OPERAND_W  = 48;
  localparam int TOTAL_W    = 56;
  localparam int NZ_W       = 9;
  localparam int PEAK_BIN_W = 8;
  localparam int PEAK_W     = 48;
  localparam int CHUNK_W    = 16;
  localparam int MUL_STEPS  = OPERAND_W / CHUNK_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_ACC    = 3'd1,
    OP_OFFSET = 3'd2,
    OP_SCALE  = 3'd3,
    OP_DIV    = 3'd4,
    OP_REPORT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_DIV
  } alu_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DEC,
    S_CLR,
    S_RD,
    S_EX,
    S_WAIT,
    S_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic we;
    logic wzero;
    logic alu_start;
    logic stat_clr;
    logic stat_acc;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic reject;
    logic last;
    logic alu_done;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/hbe_alu.sv
// ---------------------------------------------------------------------------
// hbe_alu
// Per-bin arithmetic: saturating offset, chunked multiply, restoring divide.
// ---------------------------------------------------------------------------
`default_nettype none

module hbe_alu #(
  parameter int COUNT_WIDTH = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire hbe_pkg::alu_e                 kind_i,
  input  wire logic [COUNT_WIDTH-1:0]        count_i,
  input  wire logic [hbe_pkg::OPERAND_W-1:0] mag_i,
  input  wire logic                          neg_i,
  output logic                               done_o,
  output logic [COUNT_WIDTH-1:0]             res_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int MW = hbe_pkg::OPERAND_W;
  localparam int AW = CW + MW;
  localparam int PW = CW + hbe_pkg::CHUNK_W;
  localparam int SW = $clog2(CW + 1);
  localparam logic [63:0] CMAX64 = (64'd1 << CW) - 64'd1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  hbe_pkg::alu_e       kind_q, kind_d;
  logic [SW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       c_q, c_d;
  logic [MW-1:0]       mag_q, mag_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic [MW-1:0]       rem_q, rem_d;
  logic [CW-1:0]       res_q, res_d;

  logic [63:0]         c64, m64, sum64;
  logic [CW-1:0]       add_res;
  logic [PW-1:0]       pp;
  logic [AW-1:0]       pp_sh;
  logic [MW:0]         tr;
  logic                ge;

  always_comb begin
    c64   = 64'(count_i);
    m64   = 64'(mag_i);
    sum64 = c64 + m64;
    if (neg_i) begin
      add_res = (c64 <= m64) ? '0 : CW'(c64 - m64);
    end else begin
      add_res = (sum64 >= CMAX64) ? CW'(CMAX64) : CW'(sum64);
    end
    pp = PW'(c_q) * PW'(mag_q[hbe_pkg::CHUNK_W-1:0]);
    pp_sh = AW'(pp) << (hbe_pkg::CHUNK_W * int'(cnt_q));
    tr = {rem_q, c_q[CW-1]};
    ge = tr >= {1'b0, mag_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    kind_d = kind_q;
    cnt_d  = cnt_q;
    c_d    = c_q;
    mag_d  = mag_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (start_i) begin
      kind_d = kind_i;
      cnt_d  = '0;
      c_d    = count_i;
      mag_d  = mag_i;
      acc_d  = '0;
      rem_d  = '0;
      unique case (kind_i)
        hbe_pkg::ALU_ADD: begin
          res_d  = add_res;
          done_d = 1'b1;
        end
        hbe_pkg::ALU_MUL: begin
          if (neg_i || mag_i == '0) begin
            res_d  = '0;
            done_d = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
        hbe_pkg::ALU_DIV: begin
          if (neg_i) begin
            res_d  = '0;
            done_d = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
        default: begin
          res_d  = '0;
          done_d = 1'b1;
        end
      endcase
    end else if (busy_q) begin
      if (kind_q == hbe_pkg::ALU_MUL) begin
        if (cnt_q == SW'(hbe_pkg::MUL_STEPS)) begin
          res_d  = (acc_q[AW-1:CW] != '0) ? '1 : acc_q[CW-1:0];
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          acc_d = acc_q + pp_sh;
          mag_d = mag_q >> hbe_pkg::CHUNK_W;
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        rem_d = ge ? MW'(tr - {1'b0, mag_q}) : MW'(tr);
        c_d   = {c_q[CW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SW'(CW - 1)) begin
          res_d  = {c_q[CW-2:0], ge};
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= hbe_pkg::ALU_ADD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    mag_q <= mag_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/hbe_dp.sv
// ---------------------------------------------------------------------------
// hbe_dp
// Datapath: bin memory, item registers, bin walker, report statistics and
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module hbe_dp #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hbe_pkg::cmd_t                  cmd_i,
  output hbe_pkg::stat_t                      st_o,
  input  wire logic [hbe_pkg::OP_W-1:0]       op_i,
  input  wire logic [hbe_pkg::BIN_W-1:0]      bin_i,
  input  wire logic [hbe_pkg::OPERAND_W-1:0]  operand_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_o,
  output logic [hbe_pkg::TOTAL_W-1:0]         total_o,
  output logic [hbe_pkg::NZ_W-1:0]            nonzero_bins_o,
  output logic [hbe_pkg::PEAK_BIN_W-1:0]      peak_bin_o,
  output logic [hbe_pkg::PEAK_W-1:0]          peak_count_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int IW = $clog2(BINS);
  localparam int MW = hbe_pkg::OPERAND_W;
  localparam logic [63:0] TMAX64 = (64'd1 << hbe_pkg::TOTAL_W) - 64'd1;
  localparam logic [63:0] PMAX64 = (64'd1 << hbe_pkg::PEAK_W) - 64'd1;

  logic [CW-1:0]               mem_q [BINS];
  logic [CW-1:0]               rd_q;

  hbe_pkg::op_e                op_q;
  logic [hbe_pkg::BIN_W-1:0]   bin_q;
  logic                        neg_q;
  logic [MW-1:0]               mag_q;
  logic [IW-1:0]               idx_q;
  logic [IW-1:0]               addr;

  logic [hbe_pkg::TOTAL_W-1:0]    total_q;
  logic [hbe_pkg::NZ_W-1:0]       nz_q;
  logic [CW-1:0]                  peak_q;
  logic [hbe_pkg::PEAK_BIN_W-1:0] best_q;

  logic                           out_valid_q;
  logic                           status_q;
  logic [hbe_pkg::TOTAL_W-1:0]    total_oq;
  logic [hbe_pkg::NZ_W-1:0]       nz_oq;
  logic [hbe_pkg::PEAK_BIN_W-1:0] pbin_oq;
  logic [hbe_pkg::PEAK_W-1:0]     pcount_oq;

  logic                        reject;
  logic                        bad_bin;
  logic [63:0]                 tsum, pk64;
  hbe_pkg::alu_e               kind;
  logic                        alu_done;
  logic [CW-1:0]               alu_res;

  assign addr    = (op_q == hbe_pkg::OP_ACC) ? IW'(bin_q) : idx_q;
  assign bad_bin = 32'(bin_q) >= BINS;
  assign reject  = ((op_q == hbe_pkg::OP_ACC) && (bad_bin || neg_q)) ||
                   ((op_q == hbe_pkg::OP_DIV) && (mag_q == '0));

  always_comb begin
    unique case (op_q)
      hbe_pkg::OP_SCALE: kind = hbe_pkg::ALU_MUL;
      hbe_pkg::OP_DIV:   kind = hbe_pkg::ALU_DIV;
      default:           kind = hbe_pkg::ALU_ADD;
    endcase
  end

  hbe_alu #(
    .COUNT_WIDTH(CW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.alu_start),
    .kind_i (kind),
    .count_i(rd_q),
    .mag_i  (mag_q),
    .neg_i  (neg_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr] <= cmd_i.wzero ? '0 : alu_res;
    end
    rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= hbe_pkg::OP_CLEAR;
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q <= hbe_pkg::op_e'(op_i);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= bin_i;
      neg_q <= operand_i[MW-1];
      mag_q <= operand_i[MW-1] ? MW'(-operand_i) : operand_i;
    end
  end

  assign tsum = 64'(total_q) + 64'(rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_clr) begin
      total_q <= '0;
      nz_q    <= '0;
      peak_q  <= '0;
      best_q  <= '0;
    end else if (cmd_i.stat_acc) begin
      total_q <= (tsum >= TMAX64) ? hbe_pkg::TOTAL_W'(TMAX64) : hbe_pkg::TOTAL_W'(tsum);
      if (rd_q != '0 && nz_q != '1) begin
        nz_q <= nz_q + 1'b1;
      end
      if (rd_q > peak_q) begin
        peak_q <= rd_q;
        best_q <= hbe_pkg::PEAK_BIN_W'(idx_q);
      end
    end
  end

  assign pk64 = 64'(peak_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      status_q <= reject;
      if (op_q == hbe_pkg::OP_REPORT) begin
        total_oq  <= total_q;
        nz_oq     <= nz_q;
        pbin_oq   <= best_q;
        pcount_oq <= (pk64 > PMAX64) ? '1 : hbe_pkg::PEAK_W'(pk64);
      end else begin
        total_oq  <= '0;
        nz_oq     <= '0;
        pbin_oq   <= '0;
        pcount_oq <= '0;
      end
    end
  end

  always_comb begin
    st_o.op       = op_q;
    st_o.reject   = reject;
    st_o.last     = (idx_q == IW'(BINS - 1));
    st_o.alu_done = alu_done;
    st_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign total_o        = total_oq;
  assign nonzero_bins_o = nz_oq;
  assign peak_bin_o     = pbin_oq;
  assign peak_count_o   = pcount_oq;

endmodule

`default_nettype wire

>>> rtl/hbe_ctrl.sv
// ---------------------------------------------------------------------------
// hbe_ctrl
// Sequencer: clearing pass, per-op bin walk, ALU handoff and response.
// ---------------------------------------------------------------------------
`default_nettype none
`include "histogram_bin_engine_macros.svh"

module hbe_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hbe_pkg::stat_t st_i,
  output hbe_pkg::cmd_t       cmd_o
);

  hbe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbe_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hbe_pkg::S_INIT: begin
        cmd_o.we    = 1'b1;
        cmd_o.wzero = 1'b1;
        if (st_i.last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = hbe_pkg::S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      hbe_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = hbe_pkg::S_DEC;
        end
      end
      hbe_pkg::S_DEC: begin
        priority case (st_i.op)
          hbe_pkg::OP_CLEAR:  state_d = hbe_pkg::S_CLR;
          hbe_pkg::OP_ACC,
          hbe_pkg::OP_DIV:    state_d = st_i.reject ? hbe_pkg::S_RESP : hbe_pkg::S_RD;
          hbe_pkg::OP_OFFSET,
          hbe_pkg::OP_SCALE:  state_d = hbe_pkg::S_RD;
          hbe_pkg::OP_REPORT: begin
            cmd_o.stat_clr = 1'b1;
            state_d        = hbe_pkg::S_RD;
          end
          default:            state_d = hbe_pkg::S_RESP;
        endcase
      end
      hbe_pkg::S_CLR: begin
        cmd_o.we    = 1'b1;
        cmd_o.wzero = 1'b1;
        if (st_i.last) begin
          state_d = hbe_pkg::S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      hbe_pkg::S_RD: begin
        state_d = hbe_pkg::S_EX;
      end
      hbe_pkg::S_EX: begin
        if (st_i.op == hbe_pkg::OP_REPORT) begin
          cmd_o.stat_acc = 1'b1;
          if (st_i.last) begin
            state_d = hbe_pkg::S_RESP;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = hbe_pkg::S_RD;
          end
        end else begin
          cmd_o.alu_start = 1'b1;
          state_d         = hbe_pkg::S_WAIT;
        end
      end
      hbe_pkg::S_WAIT: begin
        if (st_i.alu_done) begin
          state_d = hbe_pkg::S_WR;
        end
      end
      hbe_pkg::S_WR: begin
        cmd_o.we = 1'b1;
        if (st_i.op == hbe_pkg::OP_ACC || st_i.last) begin
          state_d = hbe_pkg::S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = hbe_pkg::S_RD;
        end
      end
      hbe_pkg::S_RESP: begin
        if (!st_i.out_busy) begin
          cmd_o.resp_load = 1'b1;
          state_d         = hbe_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hbe_pkg::S_IDLE;
      end
    endcase
  end

  `HBE_ASSERT_NOW(a_resp_no_overwrite, cmd_o.resp_load, !st_i.out_busy, "result overwritten")
  `HBE_ASSERT_NXT(a_accept_decodes, in_valid_i && in_ready_o, state_q == hbe_pkg::S_DEC, "accepted request not decoded")
  `HBE_ASSERT_NXT(a_acc_single_bin, state_q == hbe_pkg::S_WR && st_i.op == hbe_pkg::OP_ACC, state_q == hbe_pkg::S_RESP, "accumulate walked past its bin")

endmodule

`default_nettype wire

>>> rtl/histogram_bin_engine.sv
// ---------------------------------------------------------------------------
// histogram_bin_engine
// Histogram store of BINS saturating counts with clear, accumulate, offset,
// scale, divide and report ops; one result per request.
// ---------------------------------------------------------------------------
// One request is handled at a time; a new request is taken while the last
// result still waits. After reset a clearing pass over all BINS bins runs
// before the first request is taken. Run time per request is set by the single
// read port bin memory walked one bin at a time and the shared ALU: clear
// walks every bin, accumulate touches one bin, offset, scale (a 16-bit chunk
// multiplier, three passes) and divide (one quotient bit a cycle) walk every
// bin through the ALU, report walks every bin, and rejected and unused ops go
// straight to the result; any wait on the result register adds to it.
`default_nettype none

module histogram_bin_engine #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [hbe_pkg::OP_W-1:0]       op_i,
  input  wire logic [hbe_pkg::BIN_W-1:0]      bin_i,
  input  wire logic [hbe_pkg::OPERAND_W-1:0]  operand_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_o,
  output logic [hbe_pkg::TOTAL_W-1:0]         total_o,
  output logic [hbe_pkg::NZ_W-1:0]            nonzero_bins_o,
  output logic [hbe_pkg::PEAK_BIN_W-1:0]      peak_bin_o,
  output logic [hbe_pkg::PEAK_W-1:0]          peak_count_o
);

  hbe_pkg::cmd_t  cmd;
  hbe_pkg::stat_t st;

  hbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  hbe_dp #(
    .BINS       (BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .op_i          (op_i),
    .bin_i         (bin_i),
    .operand_i     (operand_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .total_o       (total_o),
    .nonzero_bins_o(nonzero_bins_o),
    .peak_bin_o    (peak_bin_o),
    .peak_count_o  (peak_count_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: histogram_bin_engine testbench
// Drives clear, accumulate, offset, scale, divide, report and unused ops on
// the request channel with random gaps and stalls. A scoreboard keeps its own
// copy of the bin counts, predicts each result in order and compares it
// field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int unsigned NUM_BINS   = 256;
  localparam int          RAND_REQS  = 1880;
  localparam int          IDLE_LIMIT = 50000;
  localparam int          HOLD_CYC   = 300;
  localparam logic [hbe_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [hbe_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MIN   = 48'h8000_0000_0000;

  typedef struct packed {
    logic                           status;
    logic [hbe_pkg::TOTAL_W-1:0]    total;
    logic [hbe_pkg::NZ_W-1:0]       nonzero;
    logic [hbe_pkg::PEAK_BIN_W-1:0] peak_bin;
    logic [hbe_pkg::PEAK_W-1:0]     peak_count;
  } hist_result_t;

  class hist_scoreboard;
    logic [47:0]  counts[NUM_BINS];
    hist_result_t pending[$];
    int           errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      errors = 0;
    endfunction

    function void note_request(logic [hbe_pkg::OP_W-1:0] op, logic [7:0] bin,
                               logic [47:0] operand);
      hist_result_t r;
      logic         neg;
      logic [47:0]  mag;
      logic [48:0]  s;
      logic [95:0]  p;
      logic [63:0]  sum;
      logic [47:0]  peak;
      int           nz;
      int           best;
      r   = '0;
      neg = operand[47];
      mag = neg ? (~operand + 48'd1) : operand;
      case (op)
        hbe_pkg::OP_CLEAR: foreach (counts[i]) counts[i] = '0;
        hbe_pkg::OP_ACC: begin
          if (neg) r.status = 1'b1;
          else begin
            s = counts[bin] + mag;
            counts[bin] = (s > COUNT_MAX) ? COUNT_MAX : s[47:0];
          end
        end
        hbe_pkg::OP_OFFSET: foreach (counts[i]) begin
          if (neg) counts[i] = (counts[i] <= mag) ? '0 : counts[i] - mag;
          else begin
            s = counts[i] + mag;
            counts[i] = (s > COUNT_MAX) ? COUNT_MAX : s[47:0];
          end
        end
        hbe_pkg::OP_SCALE: foreach (counts[i]) begin
          p = counts[i] * mag;
          if (neg || mag == 0) counts[i] = '0;
          else counts[i] = (p > COUNT_MAX) ? COUNT_MAX : p[47:0];
        end
        hbe_pkg::OP_DIV: begin
          if (mag == 0) r.status = 1'b1;
          else foreach (counts[i]) counts[i] = neg ? '0 : counts[i] / mag;
        end
        hbe_pkg::OP_REPORT: begin
          sum = 0; nz = 0; peak = 0; best = 0;
          foreach (counts[i]) begin
            sum += counts[i];
            if (counts[i] != 0) nz++;
            if (counts[i] > peak) begin
              peak = counts[i];
              best = i;
            end
          end
          r.total      = (sum > 64'hFF_FFFF_FFFF_FFFF) ? '1 : sum[hbe_pkg::TOTAL_W-1:0];
          r.nonzero    = hbe_pkg::NZ_W'(nz);
          r.peak_bin   = best[7:0];
          r.peak_count = peak;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(hist_result_t got);
      hist_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d total %0d", got.status, got.total);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.total !== exp_r.total) begin
        $error("total: expected %0d actual %0d", exp_r.total, got.total);
        errors++;
      end
      if (got.nonzero !== exp_r.nonzero) begin
        $error("nonzero_bins: expected %0d actual %0d", exp_r.nonzero, got.nonzero);
        errors++;
      end
      if (got.peak_bin !== exp_r.peak_bin) begin
        $error("peak_bin: expected %0d actual %0d", exp_r.peak_bin, got.peak_bin);
        errors++;
      end
      if (got.peak_count !== exp_r.peak_count) begin
        $error("peak_count: expected %0d actual %0d", exp_r.peak_count, got.peak_count);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [hbe_pkg::OP_W-1:0]       op_i = '0;
  logic [hbe_pkg::BIN_W-1:0]      bin_i = '0;
  logic [hbe_pkg::OPERAND_W-1:0]  operand_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           status_o;
  logic [hbe_pkg::TOTAL_W-1:0]    total_o;
  logic [hbe_pkg::NZ_W-1:0]       nonzero_bins_o;
  logic [hbe_pkg::PEAK_BIN_W-1:0] peak_bin_o;
  logic [hbe_pkg::PEAK_W-1:0]     peak_count_o;

  hist_scoreboard sb = new();
  bit             hold_req = 1'b0;
  int             idle_cnt = 0;

  histogram_bin_engine u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .bin_i, .operand_i,
    .out_valid_o, .out_ready_i, .status_o, .total_o, .nonzero_bins_o,
    .peak_bin_o, .peak_count_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(logic [hbe_pkg::OP_W-1:0] op, logic [7:0] bin,
                              logic [47:0] operand);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    bin_i      <= bin;
    operand_i  <= operand;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, bin, operand);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  function automatic logic [47:0] rand_wide();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] rand_small_signed(int lim);
    int v;
    v = $urandom_range(0, 2 * lim) - lim;
    return 48'(v);
  endfunction

  task automatic random_request();
    int          sel;
    logic [47:0] opnd;
    logic [7:0]  bin;
    sel = $urandom_range(0, 999);
    bin = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
    if (sel < 740) begin
      case ($urandom_range(0, 9))
        0:       opnd = rand_wide();
        1:       opnd = POS_MAX - 48'($urandom_range(0, 3));
        2:       opnd = rand_small_signed(5);
        default: opnd = 48'($urandom_range(0, 20));
      endcase
      send_request(hbe_pkg::OP_ACC, bin, opnd);
    end else if (sel < 830) send_request(hbe_pkg::OP_REPORT, bin, rand_wide());
    else if (sel < 870) begin
      opnd = ($urandom_range(0, 4) == 0) ? rand_wide() : rand_small_signed(6);
      send_request(hbe_pkg::OP_OFFSET, bin, opnd);
    end else if (sel < 905) begin
      opnd = ($urandom_range(0, 5) == 0) ? rand_wide() : rand_small_signed(3);
      send_request(hbe_pkg::OP_SCALE, bin, opnd);
    end else if (sel < 925) send_request(hbe_pkg::OP_CLEAR, bin, rand_wide());
    else if (sel < 980) send_request(hbe_pkg::OP_DIV, bin, 48'd0);
    else if (sel < 990) begin
      case ($urandom_range(0, 5))
        0:       opnd = rand_wide();
        1:       opnd = rand_small_signed(3);
        default: opnd = 48'($urandom_range(1, 4));
      endcase
      send_request(hbe_pkg::OP_DIV, bin, opnd);
    end else send_request($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, bin, rand_wide());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(hbe_pkg::OP_CLEAR, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_REPORT, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_ACC, 8'd0, POS_MAX);
    send_request(hbe_pkg::OP_ACC, 8'd0, POS_MAX);
    send_request(hbe_pkg::OP_ACC, 8'd0, POS_MAX);
    send_request(hbe_pkg::OP_ACC, 8'd255, 48'd1);
    send_request(hbe_pkg::OP_ACC, 8'd7, 48'd0);
    send_request(hbe_pkg::OP_ACC, 8'd3, COUNT_MAX);
    send_request(hbe_pkg::OP_ACC, 8'd3, NEG_MIN);
    send_request(hbe_pkg::OP_REPORT, 8'd255, COUNT_MAX);
    send_request(hbe_pkg::OP_OFFSET, 8'd0, 48'd5);
    send_request(hbe_pkg::OP_OFFSET, 8'd0, COUNT_MAX - 48'd2);
    send_request(hbe_pkg::OP_OFFSET, 8'd0, POS_MAX);
    send_request(hbe_pkg::OP_REPORT, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_SCALE, 8'd0, POS_MAX);
    send_request(hbe_pkg::OP_DIV, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_DIV, 8'd0, 48'd3);
    send_request(hbe_pkg::OP_REPORT, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_SCALE, 8'd0, 48'd0);
    send_request(hbe_pkg::OP_ACC, 8'd9, 48'd40);
    send_request(hbe_pkg::OP_SCALE, 8'd0, COUNT_MAX);
    send_request(hbe_pkg::OP_ACC, 8'd9, 48'd40);
    send_request(hbe_pkg::OP_DIV, 8'd0, NEG_MIN);
    send_request(OP_SPARE_A, 8'hFF, COUNT_MAX);
    send_request(OP_SPARE_B, 8'hAA, 48'h5555_5555_5555);
    send_request(hbe_pkg::OP_REPORT, 8'd0, 48'd0);

    for (int n = 0; n < RAND_REQS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 700 || n == 1400) wait_drained();
      random_request();
    end
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    int           gap;
    hist_result_t got;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYC;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{status_o, total_o, nonzero_bins_o, peak_bin_o, peak_count_o};
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
